/* design/dns_a_record_extractor_unit_macros.svh */
// Assertion macros shared by the checker of the DNS A-record extractor.
// Depends on nothing; include by bare file name.
`ifndef DNS_A_RECORD_EXTRACTOR_UNIT_MACROS_SVH
`define DNS_A_RECORD_EXTRACTOR_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define DNSX_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dnsx: implication check failed");

// Next-cycle implication, off while reset is high.
`define DNSX_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dnsx: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define DNSX_ASSERT_NXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("dnsx: reset check failed");

`endif

/* design/dnsx_pkg.sv */
// Types and constants of the DNS A-record extractor.
// Used by the top level and by its checker.
package dnsx_pkg;

   typedef logic [1:0]  status_type;
   typedef logic [31:0] address_type;
   typedef logic [15:0] field_type;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_NOTFOUND = 2'd1;
   localparam status_type ST_ERROR    = 2'd2;

   localparam logic [15:0] FLAG_QR       = 16'h8000;
   localparam logic [15:0] FLAG_TC       = 16'h0200;
   localparam logic [15:0] RCODE_MASK    = 16'h000F;
   localparam logic [15:0] RCODE_NXDOMAIN = 16'h0003;
   localparam logic [7:0]  NAME_PTR_MARK = 8'hC0;

   localparam logic [15:0] RR_TYPE_A    = 16'd1;
   localparam logic [15:0] RR_CLASS_IN  = 16'd1;
   localparam logic [15:0] RR_A_RDLEN   = 16'd4;

endpackage

/* design/dns_a_record_extractor_unit.sv */
// Top level of the DNS A-record extractor: one message byte in per word,
// one status/address word out per message. Depends on dnsx_pkg.
//
// Usage:
//   req_ channel carries one message byte per word (req_data_byte) with
//   req_last_byte marking the final byte. rsp_ channel carries one word per
//   message, issued for its last byte: rsp_status (0 found, 1 not found,
//   2 parse error) and rsp_address (zero unless found).
//   Throughput: one byte per cycle while no last byte waits for a free
//   result slot; the byte is registered and the parse state is updated
//   from it by a single pass of compare and shift logic.
//   Result path: the last byte's word passes from the input register
//   straight into the result register, which drives rsp_valid, once that
//   register is free or its result is being taken.
//   Stall: while rsp_ready is low and a result waits, bytes of the next
//   message keep flowing; only a second last byte holds in the input
//   register, and req_ready then drops until the result is taken.
//   Reset: synchronous, active high; clears both registers' valid flags and
//   the parse state, so the next byte is taken as byte 0 of a message.
//   MAX_PACKET_BYTES sets the byte limit; bytes past it force parse error.
module dns_a_record_extractor_unit
   import dnsx_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_address
);

   localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

   localparam logic [3:0] PH_HEADER = 4'd0;
   localparam logic [3:0] PH_QNAME  = 4'd1;
   localparam logic [3:0] PH_QTAIL  = 4'd2;
   localparam logic [3:0] PH_RNAME  = 4'd3;
   localparam logic [3:0] PH_RPTR   = 4'd4;
   localparam logic [3:0] PH_RSCAN  = 4'd5;
   localparam logic [3:0] PH_FIXED  = 4'd6;
   localparam logic [3:0] PH_SKIP   = 4'd7;
   localparam logic [3:0] PH_TAKE   = 4'd8;
   localparam logic [3:0] PH_DONE   = 4'd9;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // parse state
   logic [3:0]       phase_ff, phase_in;
   logic [POS_W-1:0] position_ff, position_in;
   field_type        field_count_ff, field_count_in;
   logic [7:0]       flag_byte_ff, flag_byte_in;
   field_type        record_type_ff, record_type_in;
   field_type        record_class_ff, record_class_in;
   field_type        record_length_ff, record_length_in;
   address_type      found_address_ff, found_address_in;
   status_type       verdict_ff, verdict_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   address_type rsp_address_ff, rsp_address_in;

   logic      advance;
   logic      req_take;
   logic      emit;
   field_type flags;
   field_type count_inc;
   status_type final_status;

   // A last byte needs a free result slot; other bytes always advance.
   assign advance  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take = req_valid && req_ready;
   assign emit     = advance && in_last_ff;

   assign flags     = {flag_byte_ff, in_byte_ff};
   assign count_inc = field_count_ff + 16'd1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      position_in      = position_ff;
      field_count_in   = field_count_ff;
      flag_byte_in     = flag_byte_ff;
      record_type_in   = record_type_ff;
      record_class_in  = record_class_ff;
      record_length_in = record_length_ff;
      found_address_in = found_address_ff;
      verdict_in       = verdict_ff;
      final_status     = ST_ERROR;
      rsp_status_in    = rsp_status_ff;
      rsp_address_in   = rsp_address_ff;

      if (advance) begin
         if (position_ff >= POS_W'(MAX_PACKET_BYTES)) begin
            // oversize overrides any earlier verdict
            phase_in   = PH_DONE;
            verdict_in = ST_ERROR;
         end else begin
            position_in = position_ff + POS_W'(1);
            case (phase_ff)
               PH_HEADER: begin
                  if (position_ff == POS_W'(2)) begin
                     flag_byte_in = in_byte_ff;
                  end else if (position_ff == POS_W'(3)) begin
                     if ((flags & FLAG_QR) == 16'd0 || (flags & FLAG_TC) != 16'd0) begin
                        phase_in   = PH_DONE;
                        verdict_in = ST_ERROR;
                     end else if ((flags & RCODE_MASK) == RCODE_NXDOMAIN) begin
                        phase_in   = PH_DONE;
                        verdict_in = ST_NOTFOUND;
                     end else if ((flags & RCODE_MASK) != 16'd0) begin
                        phase_in   = PH_DONE;
                        verdict_in = ST_ERROR;
                     end
                  end else if (position_ff == POS_W'(11)) begin
                     phase_in = PH_QNAME;
                  end
               end
               PH_QNAME: begin
                  if (in_byte_ff == 8'd0) begin
                     phase_in       = PH_QTAIL;
                     field_count_in = 16'd0;
                  end
               end
               PH_QTAIL: begin
                  field_count_in = count_inc;
                  if (count_inc >= 16'd4) begin
                     phase_in = PH_RNAME;
                  end
               end
               PH_RNAME: begin
                  if (in_byte_ff == NAME_PTR_MARK) begin
                     phase_in = PH_RPTR;
                  end else if (in_byte_ff == 8'd0) begin
                     phase_in       = PH_FIXED;
                     field_count_in = 16'd0;
                  end else begin
                     phase_in = PH_RSCAN;
                  end
               end
               PH_RPTR: begin
                  phase_in       = PH_FIXED;
                  field_count_in = 16'd0;
               end
               PH_RSCAN: begin
                  if (in_byte_ff == 8'd0) begin
                     phase_in       = PH_FIXED;
                     field_count_in = 16'd0;
                  end
               end
               PH_FIXED: begin
                  // type, class, ttl (dropped), rdlength
                  if (field_count_ff < 16'd2) begin
                     record_type_in = {record_type_ff[7:0], in_byte_ff};
                  end else if (field_count_ff < 16'd4) begin
                     record_class_in = {record_class_ff[7:0], in_byte_ff};
                  end else if (field_count_ff >= 16'd8) begin
                     record_length_in = {record_length_ff[7:0], in_byte_ff};
                  end
                  field_count_in = count_inc;
                  if (count_inc >= 16'd10) begin
                     if (record_type_in == RR_TYPE_A && record_class_in == RR_CLASS_IN
                         && record_length_in == RR_A_RDLEN) begin
                        phase_in         = PH_TAKE;
                        field_count_in   = 16'd0;
                        found_address_in = '0;
                     end else if (record_length_in == 16'd0) begin
                        phase_in = PH_RNAME;
                     end else begin
                        phase_in       = PH_SKIP;
                        field_count_in = record_length_in;
                     end
                  end
               end
               PH_SKIP: begin
                  if (field_count_ff > 16'd1) begin
                     field_count_in = field_count_ff - 16'd1;
                  end else begin
                     field_count_in = 16'd0;
                     phase_in       = PH_RNAME;
                  end
               end
               PH_TAKE: begin
                  found_address_in = {found_address_ff[23:0], in_byte_ff};
                  field_count_in   = count_inc;
                  if (count_inc >= 16'd4) begin
                     phase_in   = PH_DONE;
                     verdict_in = ST_OK;
                  end
               end
               default: begin
                  // verdict reached: drop bytes until the last one
               end
            endcase
         end

         if (in_last_ff) begin
            final_status   = (phase_in == PH_DONE) ? verdict_in : ST_ERROR;
            rsp_status_in  = final_status;
            rsp_address_in = (final_status == ST_OK) ? found_address_in : '0;
            // start the next message from a clean state
            phase_in       = PH_HEADER;
            position_in    = '0;
            field_count_in = '0;
            verdict_in     = ST_OK;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PH_HEADER;
         position_ff    <= '0;
         field_count_ff <= '0;
         verdict_ff     <= ST_OK;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         phase_ff       <= phase_in;
         position_ff    <= position_in;
         field_count_ff <= field_count_in;
         verdict_ff     <= verdict_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      flag_byte_ff     <= flag_byte_in;
      record_type_ff   <= record_type_in;
      record_class_ff  <= record_class_in;
      record_length_ff <= record_length_in;
      found_address_ff <= found_address_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_address_ff   <= rsp_address_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_address = rsp_address_ff;

endmodule

/* design/dnsx_checker.sv */
// Port-level checks of the DNS A-record extractor, bound to its top level.
// Depends on dnsx_pkg and dns_a_record_extractor_unit_macros.svh.
`include "dns_a_record_extractor_unit_macros.svh"

module dnsx_checker
   import dnsx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_address
);

   `DNSX_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_status != 2'd3)

   `DNSX_ASSERT_IMP(a_address_zero, clock, reset,
      rsp_valid && (rsp_status != ST_OK), rsp_address == 32'd0)

   `DNSX_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_address))

   `DNSX_ASSERT_NXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid)

endmodule

bind dns_a_record_extractor_unit dnsx_checker u_dnsx_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_address   (rsp_address)
);
